@@ rtl/adjacency_matrix_graph_store_macros.svh @@
// Assertion macros used by the graph store controller.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH

// Clocked check, quiet while reset is held.
`define AMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AMG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/amg_pkg.sv @@
// Shared constants and types of the adjacency matrix graph store.
package amg_pkg;

  localparam int AMG_MAX_NODES = 32;

  localparam logic [2:0] OP_ADD_NODE = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE = 3'd1;
  localparam logic [2:0] OP_REM_EDGE = 3'd2;
  localparam logic [2:0] OP_REM_NODE = 3'd3;
  localparam logic [2:0] OP_EXISTS   = 3'd4;
  localparam logic [2:0] OP_DEGREE   = 3'd5;
  localparam logic [2:0] OP_NEIGHB   = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_WA,
    S_EDGE_WB,
    S_EX_B,
    S_EX_C,
    S_LATCH,
    S_WALK,
    S_RM_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

@@ rtl/amg_mem.sv @@
// Edge matrix row memory: one write and one registered read port, row valid bits.
module amg_mem #(
  parameter int ROWS = amg_pkg::AMG_MAX_NODES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  amg_pkg::mem_ctl_t       ctl,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [ROWS-1:0]         wr_data,
  output logic [ROWS-1:0]         rd_data
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] valid_r;
  logic [ROWS-1:0] rd_data_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // A row never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/amg_ctrl.sv @@
// Operation sequencer: read-modify-write of matrix rows and row walks.
`include "adjacency_matrix_graph_store_macros.svh"
module amg_ctrl #(
  parameter int MAX_NODES = amg_pkg::AMG_MAX_NODES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_opcode,
  input  logic [4:0]                   in_node_a,
  input  logic [4:0]                   in_node_b,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic                         out_edge_present,
  output logic [6:0]                   out_degree_count,
  output logic [4:0]                   out_new_node_index,
  output logic [31:0]                  out_neighbour_map,
  output amg_pkg::mem_ctl_t            mctl,
  output logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic [$clog2(MAX_NODES)-1:0] wr_addr,
  output logic [MAX_NODES-1:0]         wr_data,
  input  logic [MAX_NODES-1:0]         rd_data
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int XW = (AW > 5) ? AW : 5;

  amg_pkg::state_t state_r, state_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [AW-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        x_r, x_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic                 dir_r, dir_nxt;
  logic [MAX_NODES-1:0] row_r, row_nxt;
  logic [1:0]           w_status_r, w_status_nxt;
  logic                 w_present_r, w_present_nxt;
  logic [7:0]           acc_r, acc_nxt;
  logic [4:0]           w_newidx_r, w_newidx_nxt;
  logic [31:0]          nmap_r, nmap_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           o_status_r, o_status_nxt;
  logic                 o_present_r, o_present_nxt;
  logic [6:0]           o_deg_r, o_deg_nxt;
  logic [4:0]           o_newidx_r, o_newidx_nxt;
  logic [31:0]          o_nmap_r, o_nmap_nxt;

  logic [XW-1:0]        a_ext, b_ext;
  logic                 a_ok, b_ok;
  logic [AW-1:0]        last_idx, x_idx;
  logic [CW-1:0]        x_inc;
  logic [MAX_NODES-1:0] row_mod, row_src;
  logic                 in_fire;

  assign a_ext    = XW'(in_node_a);
  assign b_ext    = XW'(in_node_b);
  assign a_ok     = a_ext < cnt_r;
  assign b_ok     = b_ext < cnt_r;
  assign last_idx = lim_r[AW-1:0];
  assign x_idx    = x_r[AW-1:0];
  assign x_inc    = CW'(x_r + 1'b1);
  assign in_fire  = in_valid && in_ready;

  assign in_ready  = (state_r == amg_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amg_pkg::S_IDLE;
      cnt_r       <= '0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    x_r         <= x_nxt;
    lim_r       <= lim_nxt;
    row_r       <= row_nxt;
    w_status_r  <= w_status_nxt;
    w_present_r <= w_present_nxt;
    acc_r       <= acc_nxt;
    w_newidx_r  <= w_newidx_nxt;
    nmap_r      <= nmap_nxt;
    o_status_r  <= o_status_nxt;
    o_present_r <= o_present_nxt;
    o_deg_r     <= o_deg_nxt;
    o_newidx_r  <= o_newidx_nxt;
    o_nmap_r    <= o_nmap_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    lim_nxt       = lim_r;
    dir_nxt       = dir_r;
    row_nxt       = row_r;
    w_status_nxt  = w_status_r;
    w_present_nxt = w_present_r;
    acc_nxt       = acc_r;
    w_newidx_nxt  = w_newidx_r;
    nmap_nxt      = nmap_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_present_nxt = o_present_r;
    o_deg_nxt     = o_deg_r;
    o_newidx_nxt  = o_newidx_r;
    o_nmap_nxt    = o_nmap_r;
    mctl          = '0;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = '0;
    row_mod       = rd_data;
    row_src       = rd_data;

    if (cfg_valid) begin
      dir_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      amg_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_opcode;
          a_nxt         = a_ext[AW-1:0];
          b_nxt         = b_ext[AW-1:0];
          x_nxt         = '0;
          w_status_nxt  = amg_pkg::ST_OK;
          w_present_nxt = 1'b0;
          acc_nxt       = '0;
          w_newidx_nxt  = '0;
          nmap_nxt      = '0;
          state_nxt     = amg_pkg::S_DONE;
          case (in_opcode)
            amg_pkg::OP_ADD_NODE: begin
              if (cnt_r == CW'(MAX_NODES)) begin
                w_status_nxt = amg_pkg::ST_FULL;
              end else begin
                w_newidx_nxt = 5'(cnt_r);
                cnt_nxt      = CW'(cnt_r + 1'b1);
              end
            end
            amg_pkg::OP_ADD_EDGE, amg_pkg::OP_REM_EDGE, amg_pkg::OP_EXISTS: begin
              if (!(a_ok && b_ok)) begin
                w_status_nxt = amg_pkg::ST_BADIDX;
              end else begin
                mctl.rd_en = 1'b1;
                rd_addr    = a_ext[AW-1:0];
                state_nxt  = (in_opcode == amg_pkg::OP_EXISTS) ? amg_pkg::S_EX_B
                                                               : amg_pkg::S_EDGE_WA;
              end
            end
            amg_pkg::OP_REM_NODE: begin
              if (!b_ok) begin
                w_status_nxt = amg_pkg::ST_BADIDX;
              end else begin
                // fetch the last row, it moves into the freed place
                lim_nxt    = CW'(cnt_r - 1'b1);
                mctl.rd_en = 1'b1;
                rd_addr    = lim_nxt[AW-1:0];
                state_nxt  = amg_pkg::S_LATCH;
              end
            end
            amg_pkg::OP_DEGREE, amg_pkg::OP_NEIGHB: begin
              if (!b_ok) begin
                w_status_nxt = amg_pkg::ST_BADIDX;
              end else begin
                lim_nxt    = cnt_r;
                mctl.rd_en = 1'b1;
                rd_addr    = b_ext[AW-1:0];
                state_nxt  = amg_pkg::S_LATCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      amg_pkg::S_EDGE_WA: begin
        row_mod      = rd_data;
        row_mod[b_r] = (op_r == amg_pkg::OP_ADD_EDGE);
        mctl.wr_en   = 1'b1;
        wr_addr      = a_r;
        wr_data      = row_mod;
        if (!dir_r && (a_r != b_r)) begin
          mctl.rd_en = 1'b1;
          rd_addr    = b_r;
          state_nxt  = amg_pkg::S_EDGE_WB;
        end else begin
          state_nxt = amg_pkg::S_DONE;
        end
      end
      amg_pkg::S_EDGE_WB: begin
        row_mod      = rd_data;
        row_mod[a_r] = (op_r == amg_pkg::OP_ADD_EDGE);
        mctl.wr_en   = 1'b1;
        wr_addr      = b_r;
        wr_data      = row_mod;
        state_nxt    = amg_pkg::S_DONE;
      end
      amg_pkg::S_EX_B: begin
        row_nxt    = rd_data;
        mctl.rd_en = 1'b1;
        rd_addr    = b_r;
        state_nxt  = amg_pkg::S_EX_C;
      end
      amg_pkg::S_EX_C: begin
        w_present_nxt = row_r[b_r] || (!dir_r && rd_data[a_r]);
        state_nxt     = amg_pkg::S_DONE;
      end
      amg_pkg::S_LATCH: begin
        row_nxt = rd_data;
        // undirected degree counts a self-loop twice
        if (op_r == amg_pkg::OP_DEGREE) begin
          acc_nxt = 8'(!dir_r && rd_data[b_r]);
        end
        if (lim_r != '0) begin
          mctl.rd_en = 1'b1;
          rd_addr    = '0;
          state_nxt  = amg_pkg::S_WALK;
        end else begin
          state_nxt = amg_pkg::S_RM_LAST;
        end
      end
      amg_pkg::S_WALK: begin
        case (op_r)
          amg_pkg::OP_REM_NODE: begin
            row_src           = (x_idx == b_r) ? row_r : rd_data;
            row_mod           = row_src;
            row_mod[b_r]      = row_src[last_idx];
            row_mod[last_idx] = 1'b0;
            mctl.wr_en        = 1'b1;
            wr_addr           = x_idx;
            wr_data           = row_mod;
          end
          amg_pkg::OP_DEGREE: begin
            acc_nxt = 8'(acc_r + 8'(row_r[x_idx]) + 8'(dir_r && rd_data[b_r]));
          end
          default: begin
            if (32'(x_r) < 32) begin
              nmap_nxt[5'(x_r)] = row_r[x_idx] || (!dir_r && rd_data[b_r]);
            end
          end
        endcase
        if (x_inc < lim_r) begin
          mctl.rd_en = 1'b1;
          rd_addr    = x_inc[AW-1:0];
          x_nxt      = x_inc;
        end else begin
          state_nxt = (op_r == amg_pkg::OP_REM_NODE) ? amg_pkg::S_RM_LAST
                                                     : amg_pkg::S_DONE;
        end
      end
      amg_pkg::S_RM_LAST: begin
        mctl.wr_en = 1'b1;
        wr_addr    = last_idx;
        wr_data    = '0;
        cnt_nxt    = lim_r;
        state_nxt  = amg_pkg::S_DONE;
      end
      amg_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = w_status_r;
          o_present_nxt = w_present_r;
          o_deg_nxt     = (acc_r > 8'd127) ? 7'd127 : acc_r[6:0];
          o_newidx_nxt  = w_newidx_r;
          o_nmap_nxt    = nmap_r;
          state_nxt     = amg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = amg_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_edge_present   = o_present_r;
  assign out_degree_count   = o_deg_r;
  assign out_new_node_index = o_newidx_r;
  assign out_neighbour_map  = o_nmap_r;

  `AMG_ASSERT(a_rw_no_overlap, (mctl.rd_en && mctl.wr_en) |-> (rd_addr != wr_addr), "row read and write collide")
  `AMG_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_NODES), "node count beyond capacity")
  `AMG_ASSERT(a_add_grows, (in_fire && in_opcode == amg_pkg::OP_ADD_NODE && cnt_r < CW'(MAX_NODES)) |=> (cnt_r == CW'($past(cnt_r) + 1'b1)), "add node did not grow count")
  `AMG_ASSERT(a_write_busy, mctl.wr_en |-> (state_r != amg_pkg::S_IDLE && state_r != amg_pkg::S_DONE), "row write outside an operation")

endmodule

@@ rtl/adjacency_matrix_graph_store.sv @@
// Top level of the adjacency matrix graph store.
//
//  channel | direction | handshake            | payload
//  in      | slave     | in_tvalid/in_tready  | tuser opcode, tdata node_a, node_b
//  out     | master    | out_tvalid/out_tready| tuser status, tdata results
//  cfg     | slave     | cfg_valid/cfg_ready  | cfg_data directed_mode
//
// Items run one at a time through a row memory with registered reads.
// Degree, neighbour and remove node walk one row per cycle.
// Reset clears the node count, the mode and the row valid bits; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile.
module adjacency_matrix_graph_store #(
  parameter int MAX_NODES = amg_pkg::AMG_MAX_NODES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // node_a[4:0], node_b[9:5], zero pad
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // edge_present[0], degree_count[7:1],
                                  // new_node_index[12:8], neighbour_map[44:13], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW = $clog2(MAX_NODES);

  amg_pkg::mem_ctl_t    mctl;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [MAX_NODES-1:0] wr_data, rd_data;
  logic                 edge_present;
  logic [6:0]           degree_count;
  logic [4:0]           new_node_index;
  logic [31:0]          neighbour_map;

  amg_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .in_opcode         (in_tuser),
    .in_node_a         (in_tdata[4:0]),
    .in_node_b         (in_tdata[9:5]),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_status        (out_tuser),
    .out_edge_present  (edge_present),
    .out_degree_count  (degree_count),
    .out_new_node_index(new_node_index),
    .out_neighbour_map (neighbour_map),
    .mctl              (mctl),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_data           (rd_data)
  );

  amg_mem #(
    .ROWS(MAX_NODES)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  assign out_tdata = {3'b000, neighbour_map, new_node_index, degree_count, edge_present};

endmodule
